// File: rtl/bptc_pkg.sv
// Shared types and constants for the barometric pressure/temperature compensation block.
// No dependencies; every other rtl file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

  // Field and calibration widths
  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int BAND_W = 2;

  // Shift amounts of the compensation formulas
  localparam int C5_SHIFT      = 8;
  localparam int TEMP_SHIFT    = 23;
  localparam int T2_SHIFT      = 31;
  localparam int OFF_C2_SHIFT  = 16;
  localparam int OFF_TC_SHIFT  = 7;
  localparam int SENS_C1_SHIFT = 15;
  localparam int SENS_TC_SHIFT = 8;
  localparam int P_MUL_SHIFT   = 21;
  localparam int P_SHIFT       = 15;

  // Internal widths, sized to the value ranges
  localparam int DT_W    = 25;
  localparam int P6_W    = 42;
  localparam int DD_W    = 50;
  localparam int PC_W    = 42;
  localparam int A_W     = 18;
  localparam int TEMP_W  = 20;
  localparam int T2_W    = 18;
  localparam int OFF1_W  = 36;
  localparam int SENS1_W = 35;
  localparam int SQ_W    = 36;
  localparam int CW_W    = 40;
  localparam int OFF_W   = 42;
  localparam int SENS_W  = 42;
  localparam int TD_W    = 21;
  localparam int PPL_W   = RAW_W + P_MUL_SHIFT;
  localparam int PPH_W   = RAW_W + 1 + SENS_W - P_MUL_SHIFT;
  localparam int Q_W     = PPH_W + 1;
  localparam int DIFF_W  = Q_W + 1;
  localparam int PS_W    = DIFF_W - P_SHIFT;
  localparam int PRES_W  = 32;

  typedef logic        [RAW_W-1:0]     raw_t;
  typedef logic        [CAL_W-1:0]     cal_word_t;
  typedef logic signed [DT_W-1:0]      dt_t;
  typedef logic signed [P6_W-1:0]      p6_t;
  typedef logic signed [DD_W-1:0]      dd_t;
  typedef logic signed [PC_W-1:0]      pc_t;
  typedef logic signed [A_W-1:0]       a_t;
  typedef logic signed [TEMP_W-1:0]    temp_t;
  typedef logic        [T2_W-1:0]      t2_t;
  typedef logic signed [OFF1_W-1:0]    off1_t;
  typedef logic signed [SENS1_W-1:0]   sens1_t;
  typedef logic signed [2*A_W-1:0]     asq_t;
  typedef logic signed [2*TEMP_W-1:0]  bsq_t;
  typedef logic        [SQ_W-1:0]      sq_t;
  typedef logic        [CW_W-1:0]      cw_t;
  typedef logic signed [OFF_W-1:0]     off_t;
  typedef logic signed [SENS_W-1:0]    sens_t;
  typedef logic signed [TD_W-1:0]      tdiff_t;
  typedef logic        [PPL_W-1:0]     ppl_t;
  typedef logic signed [PPH_W-1:0]     pph_t;
  typedef logic signed [Q_W-1:0]       q_t;
  typedef logic signed [DIFF_W-1:0]    diff_t;
  typedef logic signed [PS_W-1:0]      ps_t;
  typedef logic signed [PRES_W-1:0]    pres_t;

  // Correction band, decided on the first-order temperature
  typedef enum logic [BAND_W-1:0] {
    BAND_NONE = 2'd0,
    BAND_LOW  = 2'd1,
    BAND_COLD = 2'd2
  } band_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CAL_PRES_SENS = 3'd0,
    CAL_PRES_OFF  = 3'd1,
    CAL_SENS_TC   = 3'd2,
    CAL_OFF_TC    = 3'd3,
    CAL_REF_TEMP  = 3'd4,
    CAL_TEMP_TC   = 3'd5
  } cal_idx_t;

  // Temperature thresholds in hundredths of a degree
  localparam temp_t TEMP_REF  = 20'sd2000;
  localparam temp_t TEMP_COLD = -20'sd1500;

  // Saturation limits
  localparam tdiff_t TOUT_MAX = 21'sd524287;
  localparam tdiff_t TOUT_MIN = -21'sd524288;
  localparam ps_t    PRES_MAX = ps_t'(33'sd2147483647);
  localparam ps_t    PRES_MIN = ps_t'(-33'sd2147483648);

  typedef struct packed {
    cal_word_t pres_sens;
    cal_word_t pres_off;
    cal_word_t sens_tc;
    cal_word_t off_tc;
    cal_word_t ref_temp;
    cal_word_t temp_tc;
  } cal_t;

  // Front end to correction stages
  typedef struct packed {
    raw_t   d1;
    a_t     a;
    temp_t  b;
    temp_t  temp;
    t2_t    t2;
    off1_t  off1;
    sens1_t sens1;
    band_t  band;
  } front_t;

  // Correction stages to pressure stages
  typedef struct packed {
    raw_t  d1;
    off_t  off;
    sens_t sens;
    temp_t tout;
    band_t band;
  } corr_t;

endpackage

`default_nettype wire

// File: rtl/baro_pressure_temp_compensation_top.sv
// Top level of the barometric compensation block: calibration registers and the
// three pipeline sections. Uses bptc_pkg, bptc_temp_front, bptc_correction, bptc_pressure.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one raw pressure and one raw
//   temperature conversion per transfer. Result channel (out_valid / out_stall)
//   carries compensated temperature (0.01 C), pressure (0.01 mbar) and the
//   correction band. The receiver drives stall on each channel.
//   Calibration port (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the six
//   calibration words by index 0..5; other indexes are dropped. cfg_ready is
//   always high. Write calibration only while no transfer is in flight.
//   Pipeline: nine stage registers (three in each section), the last of them the
//   result register. Throughput: one pair per cycle while the receiver does not
//   stall; the widest multiply is the 25 x 25 bit square of the temperature
//   difference in the front section.
//   Reset (rst_n low, synchronous) clears every valid bit and the calibration
//   words to zero. When the receiver stalls, the result register holds and the
//   stages behind it keep filling until full; only then does in_stall rise.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [23:0]         in_pressure_raw,
  input  logic [23:0]         in_temperature_raw,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [19:0]  out_temperature_centi,
  output logic signed [31:0]  out_pressure_centi,
  output logic [1:0]          out_compensation_band,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  bptc_pkg::cal_t   cal_r;
  logic             front_ready;
  logic             front_valid;
  bptc_pkg::front_t front_data;
  logic             corr_ready;
  logic             corr_valid;
  bptc_pkg::corr_t  corr_data;
  logic             pres_ready;
  bptc_pkg::band_t  band;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~front_ready;
  assign out_compensation_band = band;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bptc_pkg::CAL_PRES_SENS: cal_r.pres_sens <= cfg_data;
        bptc_pkg::CAL_PRES_OFF:  cal_r.pres_off  <= cfg_data;
        bptc_pkg::CAL_SENS_TC:   cal_r.sens_tc   <= cfg_data;
        bptc_pkg::CAL_OFF_TC:    cal_r.off_tc    <= cfg_data;
        bptc_pkg::CAL_REF_TEMP:  cal_r.ref_temp  <= cfg_data;
        bptc_pkg::CAL_TEMP_TC:   cal_r.temp_tc   <= cfg_data;
        default: ;
      endcase
    end
  end

  bptc_temp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cal             (cal_r),
    .up_valid        (in_valid),
    .up_ready        (front_ready),
    .pressure_raw    (in_pressure_raw),
    .temperature_raw (in_temperature_raw),
    .dn_valid        (front_valid),
    .dn_ready        (corr_ready),
    .dn_data         (front_data)
  );

  bptc_correction u_corr (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (corr_ready),
    .up_data  (front_data),
    .dn_valid (corr_valid),
    .dn_ready (pres_ready),
    .dn_data  (corr_data)
  );

  bptc_pressure u_pres (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (corr_valid),
    .up_ready          (pres_ready),
    .up_data           (corr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (out_temperature_centi),
    .pressure_centi    (out_pressure_centi),
    .compensation_band (band)
  );

endmodule

`default_nettype wire

// File: rtl/bptc_temp_front.sv
// Front end: temperature difference, first-order temperature, band and first-order
// offset and sensitivity over three register stages. Uses bptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bptc_temp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  bptc_pkg::cal_t      cal,
  input  logic                up_valid,
  output logic                up_ready,
  input  bptc_pkg::raw_t      pressure_raw,
  input  bptc_pkg::raw_t      temperature_raw,
  output logic                dn_valid,
  input  logic                dn_ready,
  output bptc_pkg::front_t    dn_data
);

  logic [2:0] v_r;
  logic [2:0] adv;

  bptc_pkg::raw_t   a_d1_r;
  bptc_pkg::dt_t    a_dt_r;
  bptc_pkg::dt_t    a_dt_nxt;

  bptc_pkg::raw_t   b_d1_r;
  bptc_pkg::p6_t    b_p6_r;
  bptc_pkg::dd_t    b_dd_r;
  bptc_pkg::pc_t    b_p4_r;
  bptc_pkg::pc_t    b_p3_r;
  bptc_pkg::p6_t    b_p6_nxt;
  bptc_pkg::dd_t    b_dd_nxt;
  bptc_pkg::pc_t    b_p4_nxt;
  bptc_pkg::pc_t    b_p3_nxt;

  bptc_pkg::a_t     c_a_nxt;
  bptc_pkg::temp_t  c_temp_nxt;
  bptc_pkg::band_t  c_band_nxt;
  bptc_pkg::front_t c_nxt;
  bptc_pkg::front_t c_r;

  // Stage advance: a stage loads when empty or when its contents move on
  assign adv[2]   = ~v_r[2] | dn_ready;
  assign adv[1]   = ~v_r[1] | adv[2];
  assign adv[0]   = ~v_r[0] | adv[1];
  assign up_ready = adv[0];
  assign dn_valid = v_r[2];
  assign dn_data  = c_r;

  // Stage A: temperature difference against the scaled reference
  assign a_dt_nxt = $signed({1'b0, temperature_raw})
                  - $signed({1'b0, cal.ref_temp, {bptc_pkg::C5_SHIFT{1'b0}}});

  // Stage B: the four products on the temperature difference
  assign b_p6_nxt = bptc_pkg::p6_t'(a_dt_r) * bptc_pkg::p6_t'($signed({1'b0, cal.temp_tc}));
  assign b_dd_nxt = bptc_pkg::dd_t'(a_dt_r) * bptc_pkg::dd_t'(a_dt_r);
  assign b_p4_nxt = bptc_pkg::pc_t'(a_dt_r) * bptc_pkg::pc_t'($signed({1'b0, cal.off_tc}));
  assign b_p3_nxt = bptc_pkg::pc_t'(a_dt_r) * bptc_pkg::pc_t'($signed({1'b0, cal.sens_tc}));

  // Stage C: first-order temperature, band, first-order offset and sensitivity
  assign c_a_nxt = bptc_pkg::a_t'(
    b_p6_r[bptc_pkg::TEMP_SHIFT+bptc_pkg::A_W-1:bptc_pkg::TEMP_SHIFT]);
  assign c_temp_nxt = bptc_pkg::temp_t'(c_a_nxt) + bptc_pkg::TEMP_REF;

  always_comb begin
    priority if (c_temp_nxt < bptc_pkg::TEMP_COLD) begin
      c_band_nxt = bptc_pkg::BAND_COLD;
    end else if (c_temp_nxt < bptc_pkg::TEMP_REF) begin
      c_band_nxt = bptc_pkg::BAND_LOW;
    end else begin
      c_band_nxt = bptc_pkg::BAND_NONE;
    end
  end

  always_comb begin
    c_nxt.d1   = b_d1_r;
    c_nxt.a    = c_a_nxt;
    c_nxt.temp = c_temp_nxt;
    c_nxt.b    = c_temp_nxt - bptc_pkg::TEMP_COLD;
    c_nxt.band = c_band_nxt;
    c_nxt.t2   = (c_band_nxt == bptc_pkg::BAND_NONE) ? '0 :
                 b_dd_r[bptc_pkg::T2_SHIFT+bptc_pkg::T2_W-1:bptc_pkg::T2_SHIFT];
    c_nxt.off1 = bptc_pkg::off1_t'($signed({1'b0, cal.pres_off,
                                            {bptc_pkg::OFF_C2_SHIFT{1'b0}}}))
               + bptc_pkg::off1_t'($signed(b_p4_r[bptc_pkg::PC_W-1:bptc_pkg::OFF_TC_SHIFT]));
    c_nxt.sens1 = bptc_pkg::sens1_t'($signed({1'b0, cal.pres_sens,
                                              {bptc_pkg::SENS_C1_SHIFT{1'b0}}}))
                + bptc_pkg::sens1_t'($signed(b_p3_r[bptc_pkg::PC_W-1:bptc_pkg::SENS_TC_SHIFT]));
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= up_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_d1_r <= pressure_raw;
      a_dt_r <= a_dt_nxt;
    end
    if (adv[1]) begin
      b_d1_r <= a_d1_r;
      b_p6_r <= b_p6_nxt;
      b_dd_r <= b_dd_nxt;
      b_p4_r <= b_p4_nxt;
      b_p3_r <= b_p3_nxt;
    end
    if (adv[2]) begin
      c_r <= c_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bptc_correction.sv
// Second-order correction: squares, correction terms, corrected temperature,
// offset and sensitivity over three register stages. Uses bptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bptc_correction (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  bptc_pkg::front_t    up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output bptc_pkg::corr_t     dn_data
);

  logic [2:0] v_r;
  logic [2:0] adv;

  bptc_pkg::front_t d_f_r;
  bptc_pkg::sq_t    d_sq_r;
  bptc_pkg::sq_t    d_sq2_r;
  bptc_pkg::asq_t   d_asq_nxt;
  bptc_pkg::bsq_t   d_bsq_nxt;

  bptc_pkg::cw_t    e_q5;
  bptc_pkg::cw_t    e_q7;
  bptc_pkg::cw_t    e_q11;
  bptc_pkg::tdiff_t e_tdiff;
  bptc_pkg::cw_t    e_off2_nxt;
  bptc_pkg::cw_t    e_sens2_nxt;
  bptc_pkg::temp_t  e_tout_nxt;
  bptc_pkg::cw_t    e_off2_r;
  bptc_pkg::cw_t    e_sens2_r;
  bptc_pkg::temp_t  e_tout_r;
  bptc_pkg::raw_t   e_d1_r;
  bptc_pkg::off1_t  e_off1_r;
  bptc_pkg::sens1_t e_sens1_r;
  bptc_pkg::band_t  e_band_r;

  bptc_pkg::corr_t  f_nxt;
  bptc_pkg::corr_t  f_r;

  assign adv[2]   = ~v_r[2] | dn_ready;
  assign adv[1]   = ~v_r[1] | adv[2];
  assign adv[0]   = ~v_r[0] | adv[1];
  assign up_ready = adv[0];
  assign dn_valid = v_r[2];
  assign dn_data  = f_r;

  // Stage D: squares of the distances from 20 C and from -15 C
  assign d_asq_nxt = bptc_pkg::asq_t'(up_data.a) * bptc_pkg::asq_t'(up_data.a);
  assign d_bsq_nxt = bptc_pkg::bsq_t'(up_data.b) * bptc_pkg::bsq_t'(up_data.b);

  // Stage E: correction terms by shift and add, corrected temperature
  assign e_q5  = bptc_pkg::cw_t'({d_sq_r, 2'b00}) + bptc_pkg::cw_t'(d_sq_r);
  assign e_q7  = bptc_pkg::cw_t'({d_sq2_r, 3'b000}) - bptc_pkg::cw_t'(d_sq2_r);
  assign e_q11 = bptc_pkg::cw_t'({d_sq2_r, 3'b000}) + bptc_pkg::cw_t'({d_sq2_r, 1'b0})
               + bptc_pkg::cw_t'(d_sq2_r);

  always_comb begin
    unique case (d_f_r.band)
      bptc_pkg::BAND_COLD: begin
        e_off2_nxt  = (e_q5 >> 1) + e_q7;
        e_sens2_nxt = (e_q5 >> 2) + (e_q11 >> 1);
      end
      bptc_pkg::BAND_LOW: begin
        e_off2_nxt  = e_q5 >> 1;
        e_sens2_nxt = e_q5 >> 2;
      end
      default: begin
        e_off2_nxt  = '0;
        e_sens2_nxt = '0;
      end
    endcase
  end

  // Subtract the second-order term and saturate to the output range
  assign e_tdiff = bptc_pkg::tdiff_t'(d_f_r.temp) - bptc_pkg::tdiff_t'({1'b0, d_f_r.t2});

  always_comb begin
    priority if (e_tdiff > bptc_pkg::TOUT_MAX) begin
      e_tout_nxt = bptc_pkg::temp_t'(bptc_pkg::TOUT_MAX);
    end else if (e_tdiff < bptc_pkg::TOUT_MIN) begin
      e_tout_nxt = bptc_pkg::temp_t'(bptc_pkg::TOUT_MIN);
    end else begin
      e_tout_nxt = bptc_pkg::temp_t'(e_tdiff);
    end
  end

  // Stage F: corrected offset and sensitivity
  always_comb begin
    f_nxt.d1   = e_d1_r;
    f_nxt.off  = bptc_pkg::off_t'(e_off1_r) - bptc_pkg::off_t'(e_off2_r);
    f_nxt.sens = bptc_pkg::sens_t'(e_sens1_r) - bptc_pkg::sens_t'(e_sens2_r);
    f_nxt.tout = e_tout_r;
    f_nxt.band = e_band_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= up_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d_f_r   <= up_data;
      d_sq_r  <= bptc_pkg::sq_t'(d_asq_nxt);
      d_sq2_r <= d_bsq_nxt[bptc_pkg::SQ_W-1:0];
    end
    if (adv[1]) begin
      e_off2_r  <= e_off2_nxt;
      e_sens2_r <= e_sens2_nxt;
      e_tout_r  <= e_tout_nxt;
      e_d1_r    <= d_f_r.d1;
      e_off1_r  <= d_f_r.off1;
      e_sens1_r <= d_f_r.sens1;
      e_band_r  <= d_f_r.band;
    end
    if (adv[2]) begin
      f_r <= f_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bptc_pressure.sv
// Pressure stages: split raw-pressure by sensitivity product, offset subtraction,
// final shift and saturation into the output register. Uses bptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bptc_pressure (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  bptc_pkg::corr_t      up_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bptc_pkg::temp_t      temperature_centi,
  output bptc_pkg::pres_t      pressure_centi,
  output bptc_pkg::band_t      compensation_band
);

  logic [2:0] v_r;
  logic [2:0] adv;

  bptc_pkg::ppl_t   g_ppl_r;
  bptc_pkg::pph_t   g_pph_r;
  bptc_pkg::ppl_t   g_ppl_nxt;
  bptc_pkg::pph_t   g_pph_nxt;
  bptc_pkg::off_t   g_off_r;
  bptc_pkg::temp_t  g_tout_r;
  bptc_pkg::band_t  g_band_r;

  bptc_pkg::q_t     h_q_nxt;
  bptc_pkg::q_t     h_q_r;
  bptc_pkg::off_t   h_off_r;
  bptc_pkg::temp_t  h_tout_r;
  bptc_pkg::band_t  h_band_r;

  bptc_pkg::diff_t  i_diff;
  bptc_pkg::ps_t    i_ps;
  bptc_pkg::pres_t  i_pres_nxt;
  bptc_pkg::temp_t  i_temp_r;
  bptc_pkg::pres_t  i_pres_r;
  bptc_pkg::band_t  i_band_r;

  // The last stage is the output register
  assign adv[2]    = ~v_r[2] | ~out_stall;
  assign adv[1]    = ~v_r[1] | adv[2];
  assign adv[0]    = ~v_r[0] | adv[1];
  assign up_ready  = adv[0];
  assign out_valid = v_r[2];
  assign temperature_centi = i_temp_r;
  assign pressure_centi    = i_pres_r;
  assign compensation_band = i_band_r;

  // Stage G: partial products on the low (unsigned) and high (signed) sensitivity halves
  assign g_ppl_nxt = bptc_pkg::ppl_t'(up_data.d1)
                   * bptc_pkg::ppl_t'(up_data.sens[bptc_pkg::P_MUL_SHIFT-1:0]);
  assign g_pph_nxt = bptc_pkg::pph_t'($signed({1'b0, up_data.d1}))
                   * bptc_pkg::pph_t'($signed(
                       up_data.sens[bptc_pkg::SENS_W-1:bptc_pkg::P_MUL_SHIFT]));

  // Stage H: product shifted down, the high part already carries the shift
  assign h_q_nxt = bptc_pkg::q_t'(g_pph_r)
                 + bptc_pkg::q_t'(g_ppl_r[bptc_pkg::PPL_W-1:bptc_pkg::P_MUL_SHIFT]);

  // Stage I: subtract offset, shift and saturate
  assign i_diff = bptc_pkg::diff_t'(h_q_r) - bptc_pkg::diff_t'(h_off_r);
  assign i_ps   = bptc_pkg::ps_t'(i_diff[bptc_pkg::DIFF_W-1:bptc_pkg::P_SHIFT]);

  always_comb begin
    priority if (i_ps > bptc_pkg::PRES_MAX) begin
      i_pres_nxt = bptc_pkg::pres_t'(bptc_pkg::PRES_MAX);
    end else if (i_ps < bptc_pkg::PRES_MIN) begin
      i_pres_nxt = bptc_pkg::pres_t'(bptc_pkg::PRES_MIN);
    end else begin
      i_pres_nxt = bptc_pkg::pres_t'(i_ps);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= up_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
    end
  end

  // Hold each stage while the one after it is blocked
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      g_ppl_r  <= g_ppl_nxt;
      g_pph_r  <= g_pph_nxt;
      g_off_r  <= up_data.off;
      g_tout_r <= up_data.tout;
      g_band_r <= up_data.band;
    end
    if (adv[1]) begin
      h_q_r    <= h_q_nxt;
      h_off_r  <= g_off_r;
      h_tout_r <= g_tout_r;
      h_band_r <= g_band_r;
    end
    if (adv[2]) begin
      i_temp_r <= h_tout_r;
      i_pres_r <= i_pres_nxt;
      i_band_r <= h_band_r;
    end
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking bench for the barometric compensation block: directed and random
// conversion pairs, calibration writes, backpressure. Depends on bptc_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;

  localparam int  LATENCY      = 9;
  localparam int  SETTLE       = LATENCY + 6;
  localparam int  DRAIN_LIMIT  = 20000;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  PHASE_ITEMS  = 350;
  localparam logic [2:0] CAL_IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] CAL_IDX_SPARE_HI = 3'd7;
  localparam longint TEMP_REF_CENTI  = 2000;
  localparam longint TEMP_COLD_CENTI = -1500;
  localparam longint TOUT_HI = 524287;
  localparam longint TOUT_LO = -524288;
  localparam longint PRES_HI = 64'sd2147483647;
  localparam longint PRES_LO = -64'sd2147483648;

  typedef struct {
    logic signed [19:0] temp_centi;
    logic signed [31:0] pres_centi;
    bptc_pkg::band_t    band;
  } reading_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [23:0]        in_pressure_raw;
  logic [23:0]        in_temperature_raw;
  logic               out_valid;
  logic               out_stall;
  logic signed [19:0] out_temperature_centi;
  logic signed [31:0] out_pressure_centi;
  logic [1:0]         out_compensation_band;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  bptc_pkg::cal_t cal_shadow;
  reading_t pending_readings[$];
  int       mismatch_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_req_seq;
  int       hold_seen_seq;
  int       hold_left;

  baro_pressure_temp_compensation_top i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_pressure_raw       (in_pressure_raw),
    .in_temperature_raw    (in_temperature_raw),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_centi    (out_pressure_centi),
    .out_compensation_band (out_compensation_band),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // Clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Compensate one conversion pair against the given calibration words.
  // Arithmetic right shifts on longint round toward minus infinity.
  function automatic reading_t compensate_reading(bptc_pkg::raw_t d1_raw,
                                                  bptc_pkg::raw_t d2_raw,
                                                  bptc_pkg::cal_t c);
    longint d1, d2, dt, temp, t2, off2, sens2, a, b, off, sens, p, tout;
    reading_t r;
    d1    = longint'(d1_raw);
    d2    = longint'(d2_raw);
    dt    = d2 - longint'(c.ref_temp) * 256;
    temp  = TEMP_REF_CENTI + ((dt * longint'(c.temp_tc)) >>> 23);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    r.band = bptc_pkg::BAND_NONE;
    // Second-order correction below 20 C, extra term below -15 C
    if (temp < TEMP_REF_CENTI) begin
      a      = temp - TEMP_REF_CENTI;
      r.band = bptc_pkg::BAND_LOW;
      t2     = (dt * dt) >>> 31;
      off2   = (5 * a * a) >>> 1;
      sens2  = (5 * a * a) >>> 2;
      if (temp < TEMP_COLD_CENTI) begin
        b      = temp - TEMP_COLD_CENTI;
        r.band = bptc_pkg::BAND_COLD;
        off2   = off2 + 7 * b * b;
        sens2  = sens2 + ((11 * b * b) >>> 1);
      end
    end
    off  = longint'(c.pres_off) * 65536 + ((longint'(c.off_tc) * dt) >>> 7) - off2;
    sens = longint'(c.pres_sens) * 32768 + ((longint'(c.sens_tc) * dt) >>> 8) - sens2;
    p    = (((d1 * sens) >>> 21) - off) >>> 15;
    // Saturate both outputs
    tout = temp - t2;
    if (tout > TOUT_HI) tout = TOUT_HI;
    if (tout < TOUT_LO) tout = TOUT_LO;
    if (p > PRES_HI) p = PRES_HI;
    if (p < PRES_LO) p = PRES_LO;
    r.temp_centi = tout[19:0];
    r.pres_centi = p[31:0];
    return r;
  endfunction

  // Track calibration writes as the block accepts them; spare indexes are dropped
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        bptc_pkg::CAL_PRES_SENS: cal_shadow.pres_sens <= cfg_data;
        bptc_pkg::CAL_PRES_OFF:  cal_shadow.pres_off  <= cfg_data;
        bptc_pkg::CAL_SENS_TC:   cal_shadow.sens_tc   <= cfg_data;
        bptc_pkg::CAL_OFF_TC:    cal_shadow.off_tc    <= cfg_data;
        bptc_pkg::CAL_REF_TEMP:  cal_shadow.ref_temp  <= cfg_data;
        bptc_pkg::CAL_TEMP_TC:   cal_shadow.temp_tc   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Predict each accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_readings.push_back(
        compensate_reading(in_pressure_raw, in_temperature_raw, cal_shadow));
  end

  // Compare each accepted result transfer with the oldest prediction
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result transfer with no prediction pending");
        mismatch_count++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (out_temperature_centi !== exp_r.temp_centi) begin
          $error("temperature_centi: expected %0d, got %0d",
                 exp_r.temp_centi, out_temperature_centi);
          mismatch_count++;
        end
        if (out_pressure_centi !== exp_r.pres_centi) begin
          $error("pressure_centi: expected %0d, got %0d",
                 exp_r.pres_centi, out_pressure_centi);
          mismatch_count++;
        end
        if (out_compensation_band !== exp_r.band) begin
          $error("compensation_band: expected %0d, got %0d",
                 exp_r.band, out_compensation_band);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq = hold_req_seq;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left  = hold_left - 1;
    end else if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one conversion pair, idling each cycle at the sender's rate first;
  // hold until transfer
  task automatic send_reading(bptc_pkg::raw_t pres_raw, bptc_pkg::raw_t temp_raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_pressure_raw    <= pres_raw;
    in_temperature_raw <= temp_raw;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every predicted result, then let the pipe settle
  task automatic wait_results_drained();
    int spins;
    spins    = 0;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cal(logic [2:0] idx, bptc_pkg::cal_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all six words, then both spare indexes with junk that must be dropped
  task automatic write_cal_set(bptc_pkg::cal_t c);
    write_cal(bptc_pkg::CAL_PRES_SENS, c.pres_sens);
    write_cal(bptc_pkg::CAL_PRES_OFF,  c.pres_off);
    write_cal(bptc_pkg::CAL_SENS_TC,   c.sens_tc);
    write_cal(bptc_pkg::CAL_OFF_TC,    c.off_tc);
    write_cal(bptc_pkg::CAL_REF_TEMP,  c.ref_temp);
    write_cal(bptc_pkg::CAL_TEMP_TC,   c.temp_tc);
    write_cal(CAL_IDX_SPARE_LO, bptc_pkg::cal_word_t'($urandom));
    write_cal(CAL_IDX_SPARE_HI, bptc_pkg::cal_word_t'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bptc_pkg::cal_word_t pick_cal_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return bptc_pkg::cal_word_t'($urandom);
    endcase
  endfunction

  function automatic bptc_pkg::raw_t pick_raw();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return bptc_pkg::raw_t'($urandom);
    endcase
  endfunction

  // Raw temperature whose first-order result is at the given temperature (at or below 20 C);
  // lower counts land at or below it
  function automatic bptc_pkg::raw_t raw_for_temp(longint centi);
    longint k, dt, d2;
    k  = centi - TEMP_REF_CENTI;
    dt = (k >= 0) ? 0 : -(((-k) <<< 23) / longint'(cal_shadow.temp_tc));
    d2 = longint'(cal_shadow.ref_temp) * 256 + dt;
    if (d2 < 0) d2 = 0;
    if (d2 > 64'hFFFFFF) d2 = 64'hFFFFFF;
    return bptc_pkg::raw_t'(d2);
  endfunction

  // Full range half the time, else close to the reference so all bands are hit
  function automatic bptc_pkg::raw_t pick_temp_raw();
    longint d2;
    if ($urandom_range(1) == 0) return pick_raw();
    d2 = longint'(cal_shadow.ref_temp) * 256 + longint'($urandom_range(4000000)) - 2000000;
    if (d2 < 0) d2 = 0;
    if (d2 > 64'hFFFFFF) d2 = 64'hFFFFFF;
    return bptc_pkg::raw_t'(d2);
  endfunction

  // Calibration words at reset are zero: extremes of both raw fields
  task automatic test_reset_calibration();
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(24'h800000, 24'h000001);
    wait_results_drained();
  endtask

  // Band edges with a realistic calibration set
  task automatic test_band_edges();
    bptc_pkg::cal_t c;
    bptc_pkg::raw_t d2;
    c = '{pres_sens: 16'd40127, pres_off: 16'd36924, sens_tc: 16'd23317,
          off_tc: 16'd23282, ref_temp: 16'd33464, temp_tc: 16'd28312};
    write_cal_set(c);
    d2 = raw_for_temp(TEMP_REF_CENTI);
    send_reading(24'd9085466, d2);
    send_reading(24'd9085466, d2 - 1);
    d2 = raw_for_temp(TEMP_COLD_CENTI);
    send_reading(24'd9085466, d2);
    send_reading(24'd9085466, d2 - 1);
    send_reading('1, '0);
    send_reading('0, '1);
    wait_results_drained();
  endtask

  // Extreme calibration words against extreme raw values
  task automatic test_extreme_calibration();
    bptc_pkg::cal_t c;
    c = '{default: '1};
    write_cal_set(c);
    send_reading('0, '0);
    send_reading('1, '0);
    send_reading('0, '1);
    send_reading('1, '1);
    wait_results_drained();
    c = '{pres_sens: '1, pres_off: '0, sens_tc: '1, off_tc: '0, ref_temp: '0, temp_tc: '1};
    write_cal_set(c);
    send_reading('1, '1);
    send_reading('1, '0);
    wait_results_drained();
  endtask

  // Random pairs under a fresh random calibration and one idling mix
  task automatic test_random_phase(int idle_pct, int stall_pct);
    bptc_pkg::cal_t c;
    c = '{pres_sens: pick_cal_word(), pres_off: pick_cal_word(), sens_tc: pick_cal_word(),
          off_tc: pick_cal_word(), ref_temp: pick_cal_word(), temp_tc: pick_cal_word()};
    write_cal_set(c);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_reading(pick_raw(), pick_temp_raw());
    wait_results_drained();
  endtask

  // Fill the pipe behind a long receiver hold-off, pause until empty, then send a second burst and drain
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    hold_req_seq++;
    repeat (100) send_reading(pick_raw(), pick_temp_raw());
    wait_results_drained();
    repeat (50) send_reading(pick_raw(), pick_temp_raw());
    wait_results_drained();
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_pressure_raw    = '0;
    in_temperature_raw = '0;
    out_stall          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    cal_shadow         = '0;
    mismatch_count     = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_req_seq       = 0;
    hold_seen_seq      = 0;
    hold_left          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_calibration();
    test_band_edges();
    test_extreme_calibration();
    test_random_phase(0, 0);
    test_random_phase(52, 0);
    test_random_phase(0, 52);
    test_random_phase(29, 29);
    test_backpressure();

    recv_stall_pct = 0;
    wait_results_drained();
    if (pending_readings.size() != 0) begin
      $error("%0d predicted results never arrived", pending_readings.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard limit on the whole run
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bptc_pkg.sv
rtl/bptc_temp_front.sv
rtl/bptc_correction.sv
rtl/bptc_pressure.sv
rtl/baro_pressure_temp_compensation_top.sv
test/tb_top.sv
